### rtl/h76_pkg.sv
// Shared types, codes and defaults for the hixie-76 frame parser.
`timescale 1ns / 1ps
`default_nettype none

package h76_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] DIGIT_MSK = 8'h7F;
  localparam logic [7:0] MORE_BIT  = 8'h80;

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_TEXT  = 3'd1,
    ST_FF    = 3'd2,
    ST_LEN   = 3'd3,
    ST_BIN   = 3'd4
  } parse_state_t;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_END     = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    FT_TEXT   = 2'd0,
    FT_BINARY = 2'd1,
    FT_CLOSE  = 2'd2
  } frame_type_t;

  typedef struct packed {
    ev_kind_t    kind;
    frame_type_t frame_type;
    logic        has_length;
    logic [31:0] payload_length;
    logic        length_saturated;
    logic [7:0]  data_byte;
    logic        chunk_end;
  } event_t;

  // One queue entry: the first event of a byte, plus a flag for a trailing
  // frame-complete event that shares the chunk_end of the first.
  typedef struct packed {
    event_t ev;
    logic   two;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### rtl/h76_front.sv
// Front end: byte-at-a-time frame parser that turns bytes into queue entries.
`timescale 1ns / 1ps
`default_nettype none

module h76_front #(
  parameter int LENGTH_BITS = h76_pkg::LENGTH_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_chunk,
  input  wire h76_pkg::q_status_t q_stat,
  output logic                  q_push,
  output h76_pkg::entry_t       q_data
);

  h76_pkg::parse_state_t state, state_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic                   overflow, overflow_next;

  logic                   accept;
  logic                   ev_valid;

  // Length digit arithmetic
  logic                   dig_ovf;
  logic [LENGTH_BITS-1:0] dig_rem;
  logic [63:0]            dig_wide;
  logic                   dig_big;
  logic                   dig_more;
  logic                   dig_zero;
  logic                   bin_done;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && ev_valid;

  // In the type-byte state the length is cleared, so a digit after 0xFF
  // starts from zero.
  always_comb begin
    logic [LENGTH_BITS-1:0] base_rem;
    logic                   base_ovf;
    base_rem = (state == h76_pkg::ST_FF) ? '0 : remaining;
    base_ovf = (state == h76_pkg::ST_FF) ? 1'b0 : overflow;
    dig_ovf  = base_ovf || (|base_rem[LENGTH_BITS-1:LENGTH_BITS-7]);
    dig_rem  = dig_ovf ? '1 : {base_rem[LENGTH_BITS-8:0], in_byte[6:0]};
  end

  assign dig_wide = 64'(dig_rem);
  assign dig_big  = |dig_wide[63:32];
  assign dig_more = (in_byte & h76_pkg::MORE_BIT) != 8'h00;
  assign dig_zero = (dig_rem == '0);
  assign bin_done = (remaining <= LENGTH_BITS'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      h76_pkg::ST_TEXT: begin
        if (in_byte == h76_pkg::BYTE_FF) state_next = h76_pkg::ST_START;
      end
      h76_pkg::ST_FF: begin
        if (in_byte == 8'h00) state_next = h76_pkg::ST_START;
        else if (dig_more) state_next = h76_pkg::ST_LEN;
        else if (dig_zero) state_next = h76_pkg::ST_START;
        else state_next = h76_pkg::ST_BIN;
      end
      h76_pkg::ST_LEN: begin
        if (dig_more) state_next = h76_pkg::ST_LEN;
        else if (dig_zero) state_next = h76_pkg::ST_START;
        else state_next = h76_pkg::ST_BIN;
      end
      h76_pkg::ST_BIN: begin
        if (bin_done) state_next = h76_pkg::ST_START;
      end
      default: begin
        if (in_byte == h76_pkg::BYTE_FF) state_next = h76_pkg::ST_FF;
        else if ((in_byte & h76_pkg::MORE_BIT) == 8'h00) state_next = h76_pkg::ST_TEXT;
        else state_next = h76_pkg::ST_LEN;
      end
    endcase
  end

  // Outputs and datapath
  always_comb begin
    q_data              = '0;
    q_data.ev.chunk_end = in_chunk;
    ev_valid            = 1'b0;
    remaining_next      = remaining;
    overflow_next       = overflow;
    unique case (state)
      h76_pkg::ST_TEXT: begin
        ev_valid = 1'b1;
        if (in_byte == h76_pkg::BYTE_FF) begin
          q_data.ev.kind = h76_pkg::EV_END;
        end else begin
          q_data.ev.kind      = h76_pkg::EV_PAYLOAD;
          q_data.ev.data_byte = in_byte;
        end
      end
      h76_pkg::ST_FF, h76_pkg::ST_LEN: begin
        if (state == h76_pkg::ST_FF && in_byte == 8'h00) begin
          ev_valid              = 1'b1;
          q_data.two            = 1'b1;
          q_data.ev.kind        = h76_pkg::EV_HEADER;
          q_data.ev.frame_type  = h76_pkg::FT_CLOSE;
          q_data.ev.has_length  = 1'b1;
        end else begin
          remaining_next = dig_rem;
          overflow_next  = dig_ovf;
          if (!dig_more) begin
            ev_valid                   = 1'b1;
            q_data.two                 = dig_zero;
            q_data.ev.kind             = h76_pkg::EV_HEADER;
            q_data.ev.frame_type       = h76_pkg::FT_BINARY;
            q_data.ev.has_length       = 1'b1;
            q_data.ev.payload_length   = dig_big ? 32'hFFFF_FFFF : dig_wide[31:0];
            q_data.ev.length_saturated = dig_ovf || dig_big;
          end
        end
      end
      h76_pkg::ST_BIN: begin
        ev_valid            = 1'b1;
        q_data.ev.kind      = h76_pkg::EV_PAYLOAD;
        q_data.ev.data_byte = in_byte;
        q_data.two          = bin_done;
        if (remaining != '0) remaining_next = remaining - LENGTH_BITS'(1);
      end
      default: begin
        remaining_next = '0;
        overflow_next  = 1'b0;
        if (in_byte != h76_pkg::BYTE_FF && (in_byte & h76_pkg::MORE_BIT) == 8'h00) begin
          ev_valid             = 1'b1;
          q_data.ev.kind       = h76_pkg::EV_HEADER;
          q_data.ev.frame_type = h76_pkg::FT_TEXT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= h76_pkg::ST_START;
      remaining <= '0;
      overflow  <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      remaining <= remaining_next;
      overflow  <= overflow_next;
    end
  end

endmodule

`default_nettype wire

### rtl/h76_queue.sv
// Short entry queue between the parser front end and the output back end.
`timescale 1ns / 1ps
`default_nettype none

module h76_queue #(
  parameter int DEPTH = h76_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire h76_pkg::entry_t    push_data,
  input  wire logic               pop,
  output h76_pkg::entry_t         pop_data,
  output h76_pkg::q_status_t      stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  h76_pkg::entry_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/h76_back.sv
// Back end: expands queue entries into events and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module h76_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire h76_pkg::entry_t    q_data,
  input  wire h76_pkg::q_status_t q_stat,
  output logic                    q_pop,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output h76_pkg::event_t         out_ev,
  output logic                    out_last
);

  logic            pend_second;
  logic            pend_chunk;
  logic            load;
  h76_pkg::event_t end_ev;

  assign load  = !out_valid || out_ready;
  assign q_pop = load && !pend_second && !q_stat.empty;

  // Frame-complete event that trails a two-result entry
  always_comb begin
    end_ev           = '0;
    end_ev.kind      = h76_pkg::EV_END;
    end_ev.chunk_end = pend_chunk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      pend_second <= 1'b0;
    end else if (load) begin
      if (pend_second) begin
        out_valid   <= 1'b1;
        pend_second <= 1'b0;
      end else begin
        out_valid   <= !q_stat.empty;
        pend_second <= !q_stat.empty && q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_second) begin
        out_ev   <= end_ev;
        out_last <= 1'b1;
      end else begin
        out_ev     <= q_data.ev;
        out_last   <= !q_data.two;
        pend_chunk <= q_data.ev.chunk_end;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/hixie76_frame_parser.sv
// Top level of the hixie-76 WebSocket frame parser.
//
//  channel | dir | tdata                         | tuser               | tlast
//  --------+-----+-------------------------------+---------------------+-----------
//  s_*     | in  | [7:0] byte_in                 | -                   | chunk_last
//  m_*     | out | has_length, payload_length,   | event_kind,         | last
//          |     | length_saturated, data_byte,  | frame_type          |
//          |     | chunk_end                     |                     |
//
// One byte is taken per cycle while the entry queue is not full; the parser
// state, the length shift-add and the remaining-byte decrement all settle in
// that single cycle of the front end. A result passes through the entry queue
// and the output register. A byte that raises two results holds the output
// register for both in turn; the entry queue absorbs that, so input and output
// stall independently. Reset is synchronous and clears the parser state, the
// queue and the output valid; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module hixie76_frame_parser #(
  parameter int LENGTH_BITS = h76_pkg::LENGTH_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = h76_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
  input  wire logic        s_tlast,   // chunk_last
  // Event stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [0] has_length, [32:1] payload_length,
                                      // [33] length_saturated, [41:34] data_byte,
                                      // [42] chunk_end, [47:43] zero
  output logic [3:0]       m_tuser,   // [1:0] event_kind, [3:2] frame_type
  output logic             m_tlast    // last result of its input byte
);

  logic               q_push;
  logic               q_pop;
  h76_pkg::entry_t    q_in;
  h76_pkg::entry_t    q_out;
  h76_pkg::q_status_t q_stat;
  h76_pkg::event_t    out_ev;

  // Parse and classify each byte
  h76_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_chunk (s_tlast),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // Decouple parsing from delivery
  h76_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Expand entries into events and drive the output register
  h76_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_out),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_ev    (out_ev),
    .out_last  (m_tlast)
  );

  assign m_tuser = {out_ev.frame_type, out_ev.kind};
  assign m_tdata = {5'b0, out_ev.chunk_end, out_ev.data_byte, out_ev.length_saturated,
                    out_ev.payload_length, out_ev.has_length};

`ifndef SYNTHESIS
  // Never write into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("entry pushed into full queue");

  // A transfer that is not the last of its byte is followed by its frame end.
  a_second_is_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tlast && m_tuser[1:0] == h76_pkg::EV_END))
    else $error("missing frame end after non-last event");

  // A close header always has its frame end behind it.
  a_close_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == h76_pkg::EV_HEADER &&
     m_tuser[3:2] == h76_pkg::FT_CLOSE) |-> !m_tlast)
    else $error("close header marked last");
`endif

endmodule

`default_nettype wire

### tb/hixie76_frame_parser_test.sv
// Self-checking testbench for the hixie-76 frame parser: directed table plus random frames.
`timescale 1ns / 1ps

module hixie76_frame_parser_test;
  import h76_pkg::*;

  localparam int          LEN_BITS    = LENGTH_BITS_DEFAULT;
  localparam logic [63:0] LEN_MAX     = (~64'd0) >> (64 - LEN_BITS);
  localparam int          RANDOM_ITEMS = 800;
  localparam int          HOLD_AT     = 300;   // transfer count that triggers the long stall
  localparam int          HOLD_CYCLES = 400;
  localparam int          CALM_AT     = 680;   // from here on, no idling on either side
  localparam int          DRAIN_CYCLES = 20;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PRINT_CAP   = 40;

  typedef struct packed {
    event_t ev;
    logic   last;
  } expected_event_t;

  // One row of the directed table. Typed rows carry their own expectation;
  // the rest are checked against the decoder below.
  typedef struct {
    logic [7:0]  b;
    logic        cl;
    bit          typed;
    int          n;
    ev_kind_t    k0;
    frame_type_t f0;
    logic        h0;
    logic [31:0] l0;
    logic        s0;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  hixie76_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decoder state, mirrored from the block's point of view.
  parse_state_t    parser_state = ST_START;
  logic [63:0]     remaining = 64'd0;
  logic            len_ovf = 1'b0;

  // Events raised by the byte just decoded.
  expected_event_t step_events [2];
  int              step_count;
  expected_event_t pending_events [$];

  stim_row_t       stim_table [$];
  int              items_sent = 0;
  int              mismatch_count = 0;
  bit              calm = 1'b0;
  bit              hold_request = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_event(input ev_kind_t k, input frame_type_t f, input logic h,
                           input logic [31:0] l, input logic s, input logic [7:0] d,
                           input logic cl);
    expected_event_t e;
    e = '0;
    e.ev.kind = k;
    e.ev.frame_type = f;
    e.ev.has_length = h;
    e.ev.payload_length = l;
    e.ev.length_saturated = s;
    e.ev.data_byte = d;
    e.ev.chunk_end = cl;
    step_events[step_count] = e;
    step_count++;
  endtask

  // Shift in one base-128 length digit; a clear top bit closes the header.
  task automatic take_digit(input logic [7:0] b, input logic cl);
    logic [63:0] digit;
    logic        big;
    digit = 64'(b & DIGIT_MSK);
    if (len_ovf || remaining > (LEN_MAX >> 7)) begin
      remaining = LEN_MAX;
      len_ovf = 1'b1;
    end else begin
      remaining = (remaining << 7) + digit;
    end
    if ((b & MORE_BIT) == 8'd0) begin
      big = remaining > 64'hFFFF_FFFF;
      add_event(EV_HEADER, FT_BINARY, 1'b1, big ? 32'hFFFF_FFFF : remaining[31:0],
                len_ovf | big, 8'd0, cl);
      if (remaining == 64'd0) begin
        add_event(EV_END, FT_TEXT, 1'b0, 32'd0, 1'b0, 8'd0, cl);
        parser_state = ST_START;
      end else begin
        parser_state = ST_BIN;
      end
    end
  endtask

  // Advance the decoder by one byte and collect the events it raises.
  task automatic decode_byte(input logic [7:0] b, input logic cl);
    step_count = 0;
    case (parser_state)
      ST_TEXT: begin
        if (b == BYTE_FF) begin
          add_event(EV_END, FT_TEXT, 1'b0, 32'd0, 1'b0, 8'd0, cl);
          parser_state = ST_START;
        end else begin
          add_event(EV_PAYLOAD, FT_TEXT, 1'b0, 32'd0, 1'b0, b, cl);
        end
      end
      ST_FF: begin
        if (b == 8'd0) begin
          add_event(EV_HEADER, FT_CLOSE, 1'b1, 32'd0, 1'b0, 8'd0, cl);
          add_event(EV_END, FT_TEXT, 1'b0, 32'd0, 1'b0, 8'd0, cl);
          parser_state = ST_START;
        end else begin
          // 0xFF followed by a nonzero byte: that byte is the first length digit
          parser_state = ST_LEN;
          take_digit(b, cl);
        end
      end
      ST_LEN: take_digit(b, cl);
      ST_BIN: begin
        add_event(EV_PAYLOAD, FT_TEXT, 1'b0, 32'd0, 1'b0, b, cl);
        if (remaining != 64'd0) remaining = remaining - 64'd1;
        if (remaining == 64'd0) begin
          add_event(EV_END, FT_TEXT, 1'b0, 32'd0, 1'b0, 8'd0, cl);
          parser_state = ST_START;
        end
      end
      default: begin
        remaining = 64'd0;
        len_ovf = 1'b0;
        if (b == BYTE_FF) begin
          parser_state = ST_FF;
        end else if ((b & MORE_BIT) == 8'd0) begin
          add_event(EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0, 8'd0, cl);
          parser_state = ST_TEXT;
        end else begin
          parser_state = ST_LEN;
        end
      end
    endcase
  endtask

  // Mark the final event of the byte and queue everything for the checker.
  task automatic push_step();
    if (step_count > 0) step_events[step_count - 1].last = 1'b1;
    for (int i = 0; i < step_count; i++) pending_events.push_back(step_events[i]);
  endtask

  // Offer one byte, with an occasional idle burst first; return after its transfer.
  task automatic drive_byte(input logic [7:0] b, input logic cl);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= cl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (items_sent == HOLD_AT) hold_request = 1'b1;
  endtask

  // Random bytes must never open a binary frame too long to finish within
  // the run: clamp length digits so a declared length stays below 256.
  function automatic logic [7:0] keep_length_small(input logic [7:0] b);
    if (parser_state == ST_FF || parser_state == ST_LEN) begin
      if (remaining != 64'd0) return b & DIGIT_MSK;
      if ((b & MORE_BIT) != 8'd0) return MORE_BIT | (b & 8'h01);
    end
    return b;
  endfunction

  task automatic offer_byte(input logic [7:0] raw, input logic cl);
    logic [7:0] b;
    b = keep_length_small(raw);
    decode_byte(b, cl);
    push_step();
    drive_byte(b, cl);
  endtask

  function automatic logic random_chunk();
    return $urandom_range(0, 3) == 0;
  endfunction

  // One well-formed frame with random content, or a short burst of noise.
  task automatic random_frame();
    int pick;
    int len;
    int zeros;
    bit via_ff;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      offer_byte(8'($urandom_range(0, 127)), random_chunk());
      len = $urandom_range(0, 10);
      repeat (len) offer_byte(8'($urandom_range(0, 254)), random_chunk());
      offer_byte(BYTE_FF, random_chunk());
    end else if (pick < 75) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 12);
      zeros = $urandom_range(0, 2);
      via_ff = $urandom_range(0, 3) == 0;
      if (via_ff) begin
        // a lone zero digit after 0xFF would read as close
        if (len == 0 && zeros == 0) zeros = 1;
        offer_byte(BYTE_FF, random_chunk());
      end else begin
        offer_byte(8'($urandom_range(128, 254)), random_chunk());
      end
      repeat (zeros) offer_byte(MORE_BIT, random_chunk());
      if (len >= 128) begin
        offer_byte(MORE_BIT | 8'h01, random_chunk());
        offer_byte(8'(len - 128), random_chunk());
      end else begin
        offer_byte(8'(len), random_chunk());
      end
      repeat (len) offer_byte(8'($urandom_range(0, 255)), random_chunk());
    end else if (pick < 85) begin
      offer_byte(BYTE_FF, random_chunk());
      offer_byte(8'd0, random_chunk());
    end else begin
      repeat ($urandom_range(1, 6)) offer_byte(8'($urandom_range(0, 255)), random_chunk());
    end
  endtask

  function automatic stim_row_t pr(input logic [7:0] b, input logic cl);
    stim_row_t r;
    r.b = b;
    r.cl = cl;
    r.typed = 1'b0;
    r.n = 0;
    r.k0 = EV_HEADER;
    r.f0 = FT_TEXT;
    r.h0 = 1'b0;
    r.l0 = 32'd0;
    r.s0 = 1'b0;
    return r;
  endfunction

  // Typed row: first event as given; a second event, when n is 2, is frame complete.
  function automatic stim_row_t ty(input logic [7:0] b, input logic cl, input int n,
                                   input ev_kind_t k0, input frame_type_t f0,
                                   input logic h0, input logic [31:0] l0,
                                   input logic s0);
    stim_row_t r;
    r = pr(b, cl);
    r.typed = 1'b1;
    r.n = n;
    r.k0 = k0;
    r.f0 = f0;
    r.h0 = h0;
    r.l0 = l0;
    r.s0 = s0;
    return r;
  endfunction

  task automatic play_rows(input int first, input int stop);
    stim_row_t row;
    for (int i = first; i < stop; i++) begin
      row = stim_table[i];
      decode_byte(row.b, row.cl);
      if (row.typed) begin
        step_count = 0;
        if (row.n >= 1) add_event(row.k0, row.f0, row.h0, row.l0, row.s0, 8'd0, row.cl);
        if (row.n == 2) add_event(EV_END, FT_TEXT, 1'b0, 32'd0, 1'b0, 8'd0, row.cl);
      end
      push_step();
      drive_byte(row.b, row.cl);
    end
  endtask

  // Compare every event transfer with the oldest expectation, field by field.
  always @(posedge clk) begin : check_events
    expected_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event, tuser", 32'(m_tuser), 32'd0);
      end else begin
        want = pending_events.pop_front();
        if (m_tuser[1:0] !== want.ev.kind)
          report_mismatch("event_kind", 32'(m_tuser[1:0]), 32'(want.ev.kind));
        if (m_tuser[3:2] !== want.ev.frame_type)
          report_mismatch("frame_type", 32'(m_tuser[3:2]), 32'(want.ev.frame_type));
        if (m_tdata[0] !== want.ev.has_length)
          report_mismatch("has_length", 32'(m_tdata[0]), 32'(want.ev.has_length));
        if (m_tdata[32:1] !== want.ev.payload_length)
          report_mismatch("payload_length", m_tdata[32:1], want.ev.payload_length);
        if (m_tdata[33] !== want.ev.length_saturated)
          report_mismatch("length_saturated", 32'(m_tdata[33]),
                          32'(want.ev.length_saturated));
        if (m_tdata[41:34] !== want.ev.data_byte)
          report_mismatch("data_byte", 32'(m_tdata[41:34]), 32'(want.ev.data_byte));
        if (m_tdata[42] !== want.ev.chunk_end)
          report_mismatch("chunk_end", 32'(m_tdata[42]), 32'(want.ev.chunk_end));
        if (m_tlast !== want.last)
          report_mismatch("last", 32'(m_tlast), 32'(want.last));
      end
    end
  end

  // Receiver: random ready bursts, one long hold-off on request, steady at the end.
  initial begin : event_sink
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 9) < 6);
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // End the run when no transfer happens on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("[hixie76_frame_parser] ERROR");
    $finish;
  end

  initial begin : stimulus
    int tail_start;
    int tail_stop;

    // Opening: text, close, zero-length binary, 0xFF into binary, leading zero digit.
    stim_table.push_back(ty(8'h00, 1'b0, 1, EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0));
    stim_table.push_back(pr(8'h41, 1'b0));
    stim_table.push_back(pr(8'hFE, 1'b1));
    stim_table.push_back(ty(8'hFF, 1'b0, 1, EV_END, FT_TEXT, 1'b0, 32'd0, 1'b0));
    stim_table.push_back(ty(8'hFF, 1'b1, 0, EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0));
    stim_table.push_back(ty(8'h00, 1'b0, 2, EV_HEADER, FT_CLOSE, 1'b1, 32'd0, 1'b0));
    stim_table.push_back(ty(8'h80, 1'b0, 0, EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0));
    stim_table.push_back(ty(8'h00, 1'b1, 2, EV_HEADER, FT_BINARY, 1'b1, 32'd0, 1'b0));
    stim_table.push_back(ty(8'hFF, 1'b0, 0, EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0));
    stim_table.push_back(pr(8'h03, 1'b0));
    stim_table.push_back(pr(8'h00, 1'b1));
    stim_table.push_back(pr(8'hFF, 1'b0));
    stim_table.push_back(pr(8'h7F, 1'b1));
    stim_table.push_back(ty(8'hFE, 1'b0, 0, EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0));
    stim_table.push_back(pr(8'h80, 1'b1));
    stim_table.push_back(pr(8'h02, 1'b0));
    stim_table.push_back(pr(8'hAA, 1'b0));
    stim_table.push_back(pr(8'h55, 1'b1));
    stim_table.push_back(ty(8'h7F, 1'b1, 1, EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0));
    stim_table.push_back(ty(8'hFF, 1'b1, 1, EV_END, FT_TEXT, 1'b0, 32'd0, 1'b0));
    tail_start = stim_table.size();

    // Tail: a length that overflows the register. The frame can never
    // finish, so it closes the run with only a few payload bytes.
    stim_table.push_back(ty(8'h81, 1'b0, 0, EV_HEADER, FT_TEXT, 1'b0, 32'd0, 1'b0));
    repeat (5) stim_table.push_back(pr(8'hFF, 1'b0));
    stim_table.push_back(ty(8'h7F, 1'b1, 1, EV_HEADER, FT_BINARY, 1'b1,
                            32'hFFFF_FFFF, 1'b1));
    stim_table.push_back(pr(8'h00, 1'b0));
    stim_table.push_back(pr(8'hFF, 1'b1));
    stim_table.push_back(pr(8'h5A, 1'b0));
    tail_stop = stim_table.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    play_rows(0, tail_start);

    while (items_sent < RANDOM_ITEMS + tail_start) begin
      calm = items_sent >= CALM_AT;
      random_frame();
    end

    // Return to a frame boundary before the overflow tail; end an open text
    // frame at once.
    while (parser_state != ST_START)
      offer_byte((parser_state == ST_TEXT) ? BYTE_FF : 8'($urandom_range(0, 255)),
                 random_chunk());
    calm = 1'b1;
    play_rows(tail_start, tail_stop);
    s_tvalid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[hixie76_frame_parser] OK");
    end else begin
      $display("[hixie76_frame_parser] ERROR");
    end
    $finish;
  end

endmodule
